FILE: hdl/dtmf_square_tone_generator_top_defines.svh
// Assertion macros used by the tone core of the DTMF square tone generator.
`ifndef DTMF_SQUARE_TONE_GENERATOR_TOP_DEFINES_SVH
`define DTMF_SQUARE_TONE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DTMF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define DTMF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define DTMF_ASSERT_ALWAYS(label, expr)
`define DTMF_ASSERT_IMPLIES(label, ante, cons)
`endif

`endif

FILE: hdl/dtmf_sq_pkg.sv
// Package with types, constants and tone tables of the DTMF square tone generator.
`default_nettype none

package dtmf_sq_pkg;

    localparam int TICKS_PER_MS = 1000;
    localparam int HP_W         = 11;
    localparam int REM_W        = 18;
    localparam int TRIM_W       = 7;
    localparam int DIGIT_W      = 4;
    localparam int DUR_W        = 8;

    localparam logic [TRIM_W-1:0] TRIM_RESET = 7'd10;

    // Register word indexes on the configuration port.
    localparam logic REG_TIMING_TRIM = 1'b0;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [DIGIT_W-1:0]   digit;
        logic [DUR_W-1:0]     duration_ms;
    } item_t;

    typedef struct packed {
        logic low_tone_level;
        logic high_tone_level;
        logic active;
    } result_t;

    typedef struct packed {
        logic [HP_W-1:0] low_hp;
        logic [HP_W-1:0] high_hp;
        logic            silent;
    } tone_plan_t;

    // Untrimmed half periods in microseconds (500000 / frequency).
    // Pause and unused codes give zero and a silent tone.
    function automatic tone_plan_t tone_plan(input logic [DIGIT_W-1:0] digit);
        tone_plan_t p;
        p.silent = 1'b0;
        case (digit)
            4'd0:    begin p.low_hp = 11'd531;  p.high_hp = 11'd374;  end
            4'd1:    begin p.low_hp = 11'd717;  p.high_hp = 11'd413;  end
            4'd2:    begin p.low_hp = 11'd717;  p.high_hp = 11'd374;  end
            4'd3:    begin p.low_hp = 11'd717;  p.high_hp = 11'd338;  end
            4'd4:    begin p.low_hp = 11'd649;  p.high_hp = 11'd413;  end
            4'd5:    begin p.low_hp = 11'd649;  p.high_hp = 11'd374;  end
            4'd6:    begin p.low_hp = 11'd649;  p.high_hp = 11'd338;  end
            4'd7:    begin p.low_hp = 11'd586;  p.high_hp = 11'd413;  end
            4'd8:    begin p.low_hp = 11'd586;  p.high_hp = 11'd374;  end
            4'd9:    begin p.low_hp = 11'd586;  p.high_hp = 11'd338;  end
            4'd10:   begin p.low_hp = 11'd531;  p.high_hp = 11'd413;  end
            4'd11:   begin p.low_hp = 11'd531;  p.high_hp = 11'd338;  end
            4'd13:   begin p.low_hp = 11'd1428; p.high_hp = 11'd1136; end
            default: begin p.low_hp = '0; p.high_hp = '0; p.silent = 1'b1; end
        endcase
        return p;
    endfunction

    function automatic logic [HP_W-1:0] trim_hp(input logic [HP_W-1:0] hp,
                                                input logic [TRIM_W-1:0] trim);
        logic [HP_W-1:0] t;
        t = HP_W'(trim);
        return (hp > t) ? (hp - t) : '0;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dtmf_sq_cfg.sv
// Configuration register file of the DTMF square tone generator.
`default_nettype none

module dtmf_sq_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [2:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    output logic [dtmf_sq_pkg::TRIM_W-1:0]        timing_trim
);

    logic [dtmf_sq_pkg::TRIM_W-1:0] trim_reg;
    logic [dtmf_sq_pkg::TRIM_W-1:0] trim_next;
    logic                           wr_trim;

    assign pready  = 1'b1;
    assign wr_trim = psel && penable && pwrite && pready
                     && (paddr[2] == dtmf_sq_pkg::REG_TIMING_TRIM);

    always_comb
    begin
        trim_next = trim_reg;
        if (wr_trim)
        begin
            trim_next = pwdata[dtmf_sq_pkg::TRIM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trim_reg <= dtmf_sq_pkg::TRIM_RESET;
        end
        else
        begin
            trim_reg <= trim_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == dtmf_sq_pkg::REG_TIMING_TRIM)
        begin
            prdata = {{(32-dtmf_sq_pkg::TRIM_W){1'b0}}, trim_reg};
        end
    end

    assign timing_trim = trim_reg;

endmodule

`default_nettype wire

FILE: hdl/dtmf_sq_core.sv
// Tone state and its combinational update for one request.
`default_nettype none

`include "dtmf_square_tone_generator_top_defines.svh"

module dtmf_sq_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             advance,
    input  wire dtmf_sq_pkg::item_t               item,
    input  wire logic [dtmf_sq_pkg::TRIM_W-1:0]   timing_trim,
    output dtmf_sq_pkg::result_t                  result
);

    localparam int HP_W  = dtmf_sq_pkg::HP_W;
    localparam int REM_W = dtmf_sq_pkg::REM_W;

    logic [HP_W-1:0]  low_hp_reg,     low_hp_next;
    logic [HP_W-1:0]  high_hp_reg,    high_hp_next;
    logic [HP_W-1:0]  low_count_reg,  low_count_next;
    logic [HP_W-1:0]  high_count_reg, high_count_next;
    logic             low_level_reg,  low_level_next;
    logic             high_level_reg, high_level_next;
    logic             silent_reg,     silent_next;
    logic [REM_W-1:0] rem_reg,        rem_next;

    dtmf_sq_pkg::tone_plan_t plan;
    logic [HP_W-1:0]         low_inc;
    logic [HP_W-1:0]         high_inc;
    logic                    low_wrap;
    logic                    high_wrap;

    assign plan     = dtmf_sq_pkg::tone_plan(item.digit);
    assign low_inc  = low_count_reg + 1'b1;
    assign high_inc = high_count_reg + 1'b1;
    assign low_wrap  = low_inc > low_hp_reg;
    assign high_wrap = high_inc > high_hp_reg;

    always_comb
    begin
        low_hp_next     = low_hp_reg;
        high_hp_next    = high_hp_reg;
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        low_level_next  = low_level_reg;
        high_level_next = high_level_reg;
        silent_next     = silent_reg;
        rem_next        = rem_reg;
        if (item.cmd == dtmf_sq_pkg::CMD_START)
        begin
            silent_next     = plan.silent;
            low_hp_next     = dtmf_sq_pkg::trim_hp(plan.low_hp, timing_trim);
            high_hp_next    = dtmf_sq_pkg::trim_hp(plan.high_hp, timing_trim);
            low_count_next  = '0;
            high_count_next = '0;
            low_level_next  = 1'b0;
            high_level_next = 1'b0;
            rem_next        = REM_W'(REM_W'(item.duration_ms)
                                     * REM_W'(dtmf_sq_pkg::TICKS_PER_MS));
        end
        else if (rem_reg != '0)
        begin
            if (!silent_reg)
            begin
                low_count_next  = low_wrap ? '0 : low_inc;
                low_level_next  = low_level_reg ^ low_wrap;
                high_count_next = high_wrap ? '0 : high_inc;
                high_level_next = high_level_reg ^ high_wrap;
            end
            rem_next = rem_reg - 1'b1;
            // The last tick of a tone leaves both waves low and counters clear.
            if (rem_next == '0)
            begin
                low_count_next  = '0;
                high_count_next = '0;
                low_level_next  = 1'b0;
                high_level_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_hp_reg     <= '0;
            high_hp_reg    <= '0;
            low_count_reg  <= '0;
            high_count_reg <= '0;
            low_level_reg  <= 1'b0;
            high_level_reg <= 1'b0;
            silent_reg     <= 1'b1;
            rem_reg        <= '0;
        end
        else if (advance)
        begin
            low_hp_reg     <= low_hp_next;
            high_hp_reg    <= high_hp_next;
            low_count_reg  <= low_count_next;
            high_count_reg <= high_count_next;
            low_level_reg  <= low_level_next;
            high_level_reg <= high_level_next;
            silent_reg     <= silent_next;
            rem_reg        <= rem_next;
        end
    end

    assign result.low_tone_level  = low_level_next;
    assign result.high_tone_level = high_level_next;
    assign result.active          = (rem_next != '0);

    `DTMF_ASSERT_IMPLIES(a_silent_low, silent_reg, !low_level_reg && !high_level_reg)
    `DTMF_ASSERT_IMPLIES(a_idle_clear, rem_reg == '0, !low_level_reg && !high_level_reg && low_count_reg == '0 && high_count_reg == '0)
    `DTMF_ASSERT_ALWAYS(a_count_bound, low_count_reg <= low_hp_reg && high_count_reg <= high_hp_reg)

endmodule

`default_nettype wire

FILE: hdl/dtmf_square_tone_generator_top.sv
// Top level of the DTMF square tone generator: stream stages around the tone core.
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tuser: cmd; tdata: digit, duration_ms
//  m_       out  m_tvalid/m_tready  tdata: low_tone_level, high_tone_level, active
//  apb      in   psel/penable       timing_trim at byte address 0
//
// One request is accepted per cycle while s_tready is high; it waits in the input register,
// and the tone update then loads its result into the result register, to be taken on m_.
// Tone state and result register advance together when a request waits and m_ can accept.
// Reset clears the tone state to silent and idle and sets timing_trim to 10.
// A stalled m_ side holds one result and one request in flight, then drops s_tready.
`default_nettype none

module dtmf_square_tone_generator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [3:0] digit, [11:4] duration_ms, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] low_tone_level, [1] high_tone_level, [2] active
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                           in_valid_reg,  in_valid_next;
    dtmf_sq_pkg::item_t             in_item_reg;
    logic                           out_valid_reg, out_valid_next;
    dtmf_sq_pkg::result_t           out_res_reg;
    dtmf_sq_pkg::result_t           core_res;
    logic [dtmf_sq_pkg::TRIM_W-1:0] timing_trim;
    logic                           advance;
    logic                           s_take;

    dtmf_sq_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .timing_trim (timing_trim)
    );

    dtmf_sq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (in_item_reg),
        .timing_trim (timing_trim),
        .result      (core_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_item_reg.cmd         <= s_tuser[0];
            in_item_reg.digit       <= s_tdata[3:0];
            in_item_reg.duration_ms <= s_tdata[11:4];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.active, out_res_reg.high_tone_level,
                       out_res_reg.low_tone_level};

endmodule

`default_nettype wire
